### design/ufm_pkg.sv
package ufm_pkg;

    localparam int ELEM_W  = 11;
    localparam int KIND_W  = 2;
    localparam int COUNT_W = 11;
    localparam int SUM_W   = 20;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_PAD_W  = OUT_DATA_W - COUNT_W - SUM_W;

    localparam logic [KIND_W-1:0] KIND_UNION = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MOVE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_E_RD,
        ST_R_RD,
        ST_WALK,
        ST_CP_RD,
        ST_CP_WR,
        ST_Q_RD,
        ST_Q_OUT,
        ST_UPD_RDA,
        ST_UPD_SUBS,
        ST_UPD_SUBC,
        ST_UPD_RDB,
        ST_UPD_ADDS,
        ST_UPD_ADDC
    } t_state;

endpackage

### design/union_find_with_move_unit.sv
// Disjoint-set engine over elements 1..MAX_ELEMENTS with union, move and query.
// Input channel (s_axis): one operation per transfer. tuser carries the kind
// (union, move first into second's set, query), tdata carries both elements.
// Operations with an unused kind or with a used element out of range are dropped.
// Output channel (m_axis): one transfer per query with the member count and
// member sum of the queried element's set. Union and move produce nothing.
// After reset a clearing pass over all MAX_ELEMENTS slots writes the singleton
// layout into all four memories; s_axis_tready stays low during that pass.
// The block handles one operation at a time, and s_axis_tready is high only
// while it is idle. A find follows the element link and then the root links
// up to the root; compressing a chain rewrites the root link of each node in a
// read state and a write state, because each link memory has a single port.
// Results sit in an output register, so the block takes the next operation
// while a result waits. A query that finishes while the previous result is
// still stalled waits until m_axis_tready frees the register.
module union_find_with_move_unit
    import ufm_pkg::*;
#(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // Bits from the lowest up: first_element[10:0], second_element[21:11], zero pad.
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // Bits from the lowest up: kind[1:0].
    input  logic [KIND_W-1:0]     s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // Bits from the lowest up: member_count[10:0], member_sum[30:11], zero pad.
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int SLOT_W = $clog2(MAX_ELEMENTS);

    t_state               r_state, n_state;
    logic [SLOT_W-1:0]    r_clr, n_clr;
    logic [KIND_W-1:0]    r_kind, n_kind;
    logic [SLOT_W-1:0]    r_a, n_a;
    logic [SLOT_W-1:0]    r_b, n_b;
    logic                 r_side, n_side;
    logic [SLOT_W-1:0]    r_cur, n_cur;
    logic [SLOT_W-1:0]    r_r0, n_r0;
    logic [SLOT_W-1:0]    r_root, n_root;
    logic [SLOT_W-1:0]    r_ra, n_ra;
    logic [SLOT_W-1:0]    r_rb, n_rb;
    logic [SUM_W-1:0]     r_op_sum, n_op_sum;
    logic [COUNT_W-1:0]   r_op_cnt, n_op_cnt;
    logic                 r_out_valid;
    logic [COUNT_W-1:0]   r_out_cnt;
    logic [SUM_W-1:0]     r_out_sum;

    logic                 el_we, el_re, rl_we, rl_re, sm_we, sm_re, ct_we, ct_re;
    logic [SLOT_W-1:0]    el_addr, rl_addr, sm_addr, ct_addr;
    logic [SLOT_W-1:0]    el_wdata, rl_wdata, el_q, rl_q;
    logic [SUM_W-1:0]     sm_wdata, sm_q;
    logic [COUNT_W-1:0]   ct_wdata, ct_q;

    logic [SUM_W-1:0]     alu_a, alu_b, alu_y;
    logic                 alu_sub;

    logic                 out_load;
    logic                 fin;
    logic [SLOT_W-1:0]    fin_root;

    logic [ELEM_W-1:0]    in_first, in_second;
    logic                 first_ok, second_ok;
    logic [SLOT_W-1:0]    x_slot;

    assign in_first  = s_axis_tdata[ELEM_W-1:0];
    assign in_second = s_axis_tdata[2*ELEM_W-1:ELEM_W];
    assign first_ok  = (in_first != '0) && (32'(in_first) <= 32'(MAX_ELEMENTS));
    assign second_ok = (in_second != '0) && (32'(in_second) <= 32'(MAX_ELEMENTS));

    assign s_axis_tready = (r_state == ST_IDLE);
    assign x_slot        = r_side ? r_b : r_a;

    assign alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

    ufm_ram #(.DATA_W(SLOT_W), .DEPTH(MAX_ELEMENTS)) u_elem_link (
        .i_clk   (i_clk),
        .i_we    (el_we),
        .i_re    (el_re),
        .i_addr  (el_addr),
        .i_wdata (el_wdata),
        .o_rdata (el_q)
    );

    ufm_ram #(.DATA_W(SLOT_W), .DEPTH(MAX_ELEMENTS)) u_root_link (
        .i_clk   (i_clk),
        .i_we    (rl_we),
        .i_re    (rl_re),
        .i_addr  (rl_addr),
        .i_wdata (rl_wdata),
        .o_rdata (rl_q)
    );

    ufm_ram #(.DATA_W(SUM_W), .DEPTH(MAX_ELEMENTS)) u_root_sum (
        .i_clk   (i_clk),
        .i_we    (sm_we),
        .i_re    (sm_re),
        .i_addr  (sm_addr),
        .i_wdata (sm_wdata),
        .o_rdata (sm_q)
    );

    ufm_ram #(.DATA_W(COUNT_W), .DEPTH(MAX_ELEMENTS)) u_root_count (
        .i_clk   (i_clk),
        .i_we    (ct_we),
        .i_re    (ct_re),
        .i_addr  (ct_addr),
        .i_wdata (ct_wdata),
        .o_rdata (ct_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_side      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_side  <= n_side;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_a      <= n_a;
        r_b      <= n_b;
        r_cur    <= n_cur;
        r_r0     <= n_r0;
        r_root   <= n_root;
        r_ra     <= n_ra;
        r_rb     <= n_rb;
        r_op_sum <= n_op_sum;
        r_op_cnt <= n_op_cnt;
        if (out_load) begin
            r_out_cnt <= ct_q;
            r_out_sum <= sm_q;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_kind   = r_kind;
        n_a      = r_a;
        n_b      = r_b;
        n_side   = r_side;
        n_cur    = r_cur;
        n_r0     = r_r0;
        n_root   = r_root;
        n_ra     = r_ra;
        n_rb     = r_rb;
        n_op_sum = r_op_sum;
        n_op_cnt = r_op_cnt;

        el_we    = 1'b0;
        el_re    = 1'b0;
        el_addr  = x_slot;
        el_wdata = r_rb;
        rl_we    = 1'b0;
        rl_re    = 1'b0;
        rl_addr  = r_cur;
        rl_wdata = r_root;
        sm_we    = 1'b0;
        sm_re    = 1'b0;
        sm_addr  = r_ra;
        sm_wdata = alu_y;
        ct_we    = 1'b0;
        ct_re    = 1'b0;
        ct_addr  = r_ra;
        ct_wdata = COUNT_W'(alu_y);

        alu_a    = sm_q;
        alu_b    = r_op_sum;
        alu_sub  = 1'b0;

        out_load = 1'b0;
        fin      = 1'b0;
        fin_root = r_cur;

        case (r_state)
            ST_CLEAR: begin
                el_we    = 1'b1;
                el_addr  = r_clr;
                el_wdata = r_clr;
                rl_we    = 1'b1;
                rl_addr  = r_clr;
                rl_wdata = r_clr;
                sm_we    = 1'b1;
                sm_addr  = r_clr;
                sm_wdata = SUM_W'(32'(r_clr) + 32'd1);
                ct_we    = 1'b1;
                ct_addr  = r_clr;
                ct_wdata = COUNT_W'(1);
                n_clr    = r_clr + SLOT_W'(1);
                if (r_clr == SLOT_W'(MAX_ELEMENTS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_kind   = s_axis_tuser;
                    n_a      = SLOT_W'(32'(in_first) - 32'd1);
                    n_b      = SLOT_W'(32'(in_second) - 32'd1);
                    n_side   = 1'b0;
                    n_op_sum = SUM_W'(in_first);
                    n_op_cnt = COUNT_W'(1);
                    if (s_axis_tuser == KIND_QUERY && first_ok) begin
                        n_state = ST_E_RD;
                    end else if ((s_axis_tuser == KIND_UNION || s_axis_tuser == KIND_MOVE)
                                 && first_ok && second_ok) begin
                        n_state = ST_E_RD;
                    end
                end
            end
            ST_E_RD: begin
                el_re   = 1'b1;
                n_state = ST_R_RD;
            end
            ST_R_RD: begin
                rl_re   = 1'b1;
                rl_addr = el_q;
                n_cur   = el_q;
                n_r0    = el_q;
                n_state = ST_WALK;
            end
            ST_WALK: begin
                if (rl_q == r_cur) begin
                    if (r_r0 == r_cur) begin
                        fin      = 1'b1;
                        fin_root = r_cur;
                    end else begin
                        el_we    = 1'b1;
                        el_wdata = r_cur;
                        n_root   = r_cur;
                        n_cur    = r_r0;
                        n_state  = ST_CP_RD;
                    end
                end else begin
                    rl_re   = 1'b1;
                    rl_addr = rl_q;
                    n_cur   = rl_q;
                end
            end
            ST_CP_RD: begin
                rl_re   = 1'b1;
                n_state = ST_CP_WR;
            end
            ST_CP_WR: begin
                rl_we = 1'b1;
                n_cur = rl_q;
                if (rl_q == r_root) begin
                    fin      = 1'b1;
                    fin_root = r_root;
                end else begin
                    n_state = ST_CP_RD;
                end
            end
            ST_Q_RD: begin
                sm_re   = 1'b1;
                ct_re   = 1'b1;
                n_state = ST_Q_OUT;
            end
            ST_Q_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            ST_UPD_RDA: begin
                sm_re = 1'b1;
                ct_re = 1'b1;
                if (r_kind == KIND_UNION) begin
                    rl_we    = 1'b1;
                    rl_addr  = r_ra;
                    rl_wdata = r_rb;
                    n_state  = ST_UPD_RDB;
                end else begin
                    el_we    = 1'b1;
                    el_addr  = r_a;
                    el_wdata = r_rb;
                    n_state  = ST_UPD_SUBS;
                end
            end
            ST_UPD_SUBS: begin
                alu_sub = 1'b1;
                sm_we   = 1'b1;
                n_state = ST_UPD_SUBC;
            end
            ST_UPD_SUBC: begin
                alu_a   = SUM_W'(ct_q);
                alu_b   = SUM_W'(r_op_cnt);
                alu_sub = 1'b1;
                ct_we   = 1'b1;
                n_state = ST_UPD_RDB;
            end
            ST_UPD_RDB: begin
                sm_re   = 1'b1;
                sm_addr = r_rb;
                ct_re   = 1'b1;
                ct_addr = r_rb;
                if (r_kind == KIND_UNION) begin
                    n_op_sum = sm_q;
                    n_op_cnt = ct_q;
                end
                n_state = ST_UPD_ADDS;
            end
            ST_UPD_ADDS: begin
                sm_we   = 1'b1;
                sm_addr = r_rb;
                n_state = ST_UPD_ADDC;
            end
            ST_UPD_ADDC: begin
                alu_a   = SUM_W'(ct_q);
                alu_b   = SUM_W'(r_op_cnt);
                ct_we   = 1'b1;
                ct_addr = r_rb;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // The first find of an operation resolves the first element, the second
        // one the target element of a union or a move.
        if (fin) begin
            if (!r_side) begin
                n_ra = fin_root;
                if (r_kind == KIND_QUERY) begin
                    n_state = ST_Q_RD;
                end else begin
                    n_side  = 1'b1;
                    n_state = ST_E_RD;
                end
            end else begin
                n_rb    = fin_root;
                n_state = (fin_root == r_ra) ? ST_IDLE : ST_UPD_RDA;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out_sum, r_out_cnt};

    a_update_distinct_roots: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD_RDA) |-> (r_ra != r_rb)
    ) else $error("Set update started on two equal roots.");

    a_result_from_query: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_Q_OUT)
    ) else $error("Result appeared outside of a query.");

    a_compress_below_root: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CP_WR) |-> (r_cur != r_root)
    ) else $error("Path compression rewrote the root link.");

endmodule

### design/ufm_ram.sv
module ufm_ram #(
    parameter int DATA_W = 11,
    parameter int DEPTH  = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic                       i_re,
    input  logic [$clog2(DEPTH)-1:0]   i_addr,
    input  logic [DATA_W-1:0]          i_wdata,
    output logic [DATA_W-1:0]          o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### bench/tb_union_find_with_move_unit.sv
module tb_union_find_with_move_unit
    import ufm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_ELEM       = 1024;
    localparam int N_NODES      = 2 * N_ELEM;
    localparam int RANDOM_OPS   = 1230;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 100;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [ELEM_W-1:0] first_elem;
        logic [ELEM_W-1:0] second_elem;
    } t_set_op;

    typedef struct {
        logic [COUNT_W-1:0] count;
        logic [SUM_W-1:0]   sum;
    } t_set_stats;

    typedef struct {
        t_set_op    op;
        bit         typed;
        t_set_stats stats;
    } t_directed_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [KIND_W-1:0]     s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int          link_of [N_NODES];
    longint      set_sum [N_ELEM];
    longint      set_count [N_ELEM];
    t_set_stats  pending_stats [$];
    int          error_count;
    int          cycle_count;
    int          src_idle_pct;
    int          sink_stall_pct;
    t_directed_row directed_rows [20];

    union_find_with_move_unit #(
        .MAX_ELEMENTS(N_ELEM)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $realtime, cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99, 0) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        t_set_stats want;
        logic [COUNT_W-1:0] got_count;
        logic [SUM_W-1:0]   got_sum;
        got_count = m_axis_tdata[COUNT_W-1:0];
        got_sum   = m_axis_tdata[COUNT_W +: SUM_W];
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_stats.size() == 0) begin
                $display("%0t: unexpected result count=%0d sum=%0d", $realtime,
                         got_count, got_sum);
                error_count++;
            end else begin
                want = pending_stats.pop_front();
                if (got_count !== want.count) begin
                    $display("%0t: member_count expected %0d actual %0d", $realtime,
                             want.count, got_count);
                    error_count++;
                end
                if (got_sum !== want.sum) begin
                    $display("%0t: member_sum expected %0d actual %0d", $realtime,
                             want.sum, got_sum);
                    error_count++;
                end
            end
        end
    end

    function automatic bit elem_ok(input logic [ELEM_W-1:0] e);
        return e >= 1 && e <= N_ELEM;
    endfunction

    function automatic int root_of(input int node);
        int r;
        int cur;
        int nxt;
        int steps;
        r = node;
        steps = 0;
        while (link_of[r] != r && steps < N_NODES) begin
            r = link_of[r];
            steps++;
        end
        cur = node;
        steps = 0;
        while (cur != r && steps < N_NODES) begin
            nxt = link_of[cur];
            link_of[cur] = r;
            cur = nxt;
            steps++;
        end
        return r;
    endfunction

    function automatic void reset_sets();
        for (int j = 0; j < N_ELEM; j++) begin
            link_of[j] = N_ELEM + j;
            link_of[N_ELEM + j] = N_ELEM + j;
            set_sum[j] = j + 1;
            set_count[j] = 1;
        end
    endfunction

    // Applies one operation to the shadow forest; returns 1 when it yields a result.
    function automatic bit apply_op(input t_set_op op, output t_set_stats stats);
        int na;
        int nb;
        int ra;
        int rb;
        int sa;
        int sb;
        stats = '{default: '0};
        if (op.kind == KIND_UNUSED || !elem_ok(op.first_elem))
            return 0;
        na = op.first_elem - 1;
        if (op.kind == KIND_QUERY) begin
            sa = root_of(na) - N_ELEM;
            stats.count = set_count[sa][COUNT_W-1:0];
            stats.sum   = set_sum[sa][SUM_W-1:0];
            return 1;
        end
        if (!elem_ok(op.second_elem))
            return 0;
        nb = op.second_elem - 1;
        ra = root_of(na);
        rb = root_of(nb);
        if (ra == rb)
            return 0;
        sa = ra - N_ELEM;
        sb = rb - N_ELEM;
        if (op.kind == KIND_UNION) begin
            link_of[ra] = rb;
            set_sum[sb] += set_sum[sa];
            set_count[sb] += set_count[sa];
        end else begin
            link_of[na] = rb;
            set_sum[sb] += op.first_elem;
            set_sum[sa] -= op.first_elem;
            set_count[sb] += 1;
            set_count[sa] -= 1;
        end
        return 0;
    endfunction

    // Drives one operation and returns at the edge where it is transferred.
    task automatic send_op(input t_set_op op, output t_set_stats stats, output bit has_res);
        while ($urandom_range(99, 0) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op.kind;
        s_axis_tdata  <= {2'b00, op.second_elem, op.first_elem};
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        has_res = apply_op(op, stats);
    endtask

    function automatic logic [ELEM_W-1:0] pick_elem(input int base, input int span);
        if ($urandom_range(99, 0) < 4) begin
            if ($urandom_range(3, 0) == 0)
                return '0;
            return ELEM_W'($urandom_range(2047, N_ELEM + 1));
        end
        return ELEM_W'(base + $urandom_range(span - 1, 0));
    endfunction

    initial begin
        t_set_op    op;
        t_set_stats stats;
        bit         has_res;
        int         sent_ops;
        int         span;
        int         base;
        int         roll;

        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = KIND_UNION;
        m_axis_tready  = 1'b0;
        error_count    = 0;
        cycle_count    = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        reset_sets();

        directed_rows[0]  = '{'{KIND_QUERY, 11'd1, 11'd1}, 1, '{11'd1, 20'd1}};
        directed_rows[1]  = '{'{KIND_QUERY, 11'd1024, 11'd2047}, 1, '{11'd1, 20'd1024}};
        directed_rows[2]  = '{'{KIND_QUERY, 11'd5, 11'd0}, 1, '{11'd1, 20'd5}};
        directed_rows[3]  = '{'{KIND_QUERY, 11'd0, 11'd3}, 0, '{'0, '0}};
        directed_rows[4]  = '{'{KIND_QUERY, 11'd1025, 11'd3}, 0, '{'0, '0}};
        directed_rows[5]  = '{'{KIND_QUERY, 11'd2047, 11'd2047}, 0, '{'0, '0}};
        directed_rows[6]  = '{'{KIND_UNUSED, 11'd1, 11'd2}, 0, '{'0, '0}};
        directed_rows[7]  = '{'{KIND_UNION, 11'd0, 11'd2}, 0, '{'0, '0}};
        directed_rows[8]  = '{'{KIND_UNION, 11'd1, 11'd2047}, 0, '{'0, '0}};
        directed_rows[9]  = '{'{KIND_UNION, 11'd1, 11'd2}, 0, '{'0, '0}};
        directed_rows[10] = '{'{KIND_UNION, 11'd2, 11'd1}, 0, '{'0, '0}};
        directed_rows[11] = '{'{KIND_UNION, 11'd1024, 11'd1}, 0, '{'0, '0}};
        directed_rows[12] = '{'{KIND_QUERY, 11'd2, 11'd0}, 0, '{'0, '0}};
        directed_rows[13] = '{'{KIND_MOVE, 11'd1, 11'd3}, 0, '{'0, '0}};
        directed_rows[14] = '{'{KIND_MOVE, 11'd1, 11'd3}, 0, '{'0, '0}};
        directed_rows[15] = '{'{KIND_MOVE, 11'd2, 11'd1025}, 0, '{'0, '0}};
        directed_rows[16] = '{'{KIND_MOVE, 11'd2, 11'd5}, 0, '{'0, '0}};
        directed_rows[17] = '{'{KIND_MOVE, 11'd1024, 11'd5}, 0, '{'0, '0}};
        directed_rows[18] = '{'{KIND_QUERY, 11'd5, 11'd1}, 0, '{'0, '0}};
        directed_rows[19] = '{'{KIND_QUERY, 11'd3, 11'd1}, 0, '{'0, '0}};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            send_op(directed_rows[i].op, stats, has_res);
            if (has_res)
                pending_stats.push_back(directed_rows[i].typed ? directed_rows[i].stats : stats);
        end

        sent_ops = 0;
        span = 8;
        base = 1;
        while (sent_ops < RANDOM_OPS) begin
            case (sent_ops * 4 / RANDOM_OPS)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 69; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 69; end
                default: begin src_idle_pct = 35; sink_stall_pct = 35; end
            endcase
            // Work on a window of elements for a while so that sets grow and split.
            if ($urandom_range(63, 0) == 0) begin
                case ($urandom_range(3, 0))
                    0: span = 8;
                    1: span = 32;
                    2: span = 128;
                    default: span = N_ELEM;
                endcase
                base = $urandom_range(N_ELEM + 1 - span, 1);
            end
            roll = $urandom_range(99, 0);
            if (roll < 30)
                op.kind = KIND_UNION;
            else if (roll < 60)
                op.kind = KIND_MOVE;
            else if (roll < 96)
                op.kind = KIND_QUERY;
            else
                op.kind = KIND_UNUSED;
            op.first_elem  = pick_elem(base, span);
            op.second_elem = pick_elem(base, span);
            sent_ops++;
            send_op(op, stats, has_res);
            if (has_res)
                pending_stats.push_back(stats);
        end
        s_axis_tvalid <= 1'b0;

        while (pending_stats.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### union_find_with_move_unit.f
design/ufm_pkg.sv
design/ufm_ram.sv
design/union_find_with_move_unit.sv
bench/tb_union_find_with_move_unit.sv
